// File: sv/dmrr_pkg.sv
// Shared constants and types for the distance matrix road restoration block.
package dmrr_pkg;

  localparam int DIST_W         = 30;
  localparam int SIZE_W         = 7;
  localparam int TOTAL_W        = 41;
  localparam int SIZE_EXT_W     = 9;
  localparam int MAX_NODES_DEF  = 64;
  localparam int DIST_BITS_DEF  = 30;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd3;

  typedef struct packed {
    logic               status;
    logic [TOTAL_W-1:0] total_length;
  } result_t;

endpackage

// File: sv/dmrr_ifs.sv
// Channel interfaces: matrix entry input, result output, size configuration.
interface dmrr_in_if;
  logic                        valid;
  logic                        ready;
  logic [dmrr_pkg::DIST_W-1:0] distance;
  modport source (output valid, output distance, input ready);
  modport sink (input valid, input distance, output ready);
endinterface

interface dmrr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [dmrr_pkg::TOTAL_W-1:0] total_length;
  modport source (output valid, output status, output total_length, input ready);
  modport sink (input valid, input status, input total_length, output ready);
endinterface

interface dmrr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [dmrr_pkg::SIZE_W-1:0] matrix_size;
  modport source (output valid, output matrix_size, input ready);
  modport sink (input valid, input matrix_size, output ready);
endinterface

// File: sv/dmrr_store.sv
// Distance store: one write port, two registered read ports.
module dmrr_store #(
  parameter int AW = 12,
  parameter int DW = 30
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  localparam int Depth = 1 << AW;

  logic [DW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: sv/dmrr_eval.sv
// Evaluation sequencer: triangle check and needed-edge sum over the stored matrix.
module dmrr_eval #(
  parameter int MAX_NODES = dmrr_pkg::MAX_NODES_DEF,
  parameter int DIST_BITS = dmrr_pkg::DIST_BITS_DEF,
  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  localparam int AW = 2 * IW
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [IW-1:0]            nm1,
  output logic [AW-1:0]            raddr_a,
  output logic [AW-1:0]            raddr_b,
  input  logic [DIST_BITS-1:0]     rdata_a,
  input  logic [DIST_BITS-1:0]     rdata_b,
  output logic                     done,
  output dmrr_pkg::result_t        result
);

  localparam int DW1 = DIST_BITS + 1;
  localparam int SW  = DIST_BITS + 2 * IW + 1;

  typedef enum logic [4:0] {
    G_IDLE  = 5'b00001,
    G_PAIR  = 5'b00010,
    G_K0    = 5'b00100,
    G_K1    = 5'b01000,
    G_FLUSH = 5'b10000
  } gstate_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PAIR,
    OP_K0,
    OP_K1,
    OP_FLUSH
  } op_t;

  gstate_t              gstate;
  op_t                  op;
  logic [IW-1:0]        i;
  logic [IW-1:0]        j;
  logic [IW-1:0]        k;
  logic                 pair_init;
  logic [DIST_BITS-1:0] dij;
  logic                 needed;
  logic                 viol;
  logic [SW-1:0]        sum;

  logic                 skip_k;
  logic                 k_last;
  logic                 j_last;
  logic                 i_last;
  logic                 end_pair;
  logic [DW1-1:0]       k0_lhs;
  logic [DW1-1:0]       k1_rhs;
  logic [SW-1:0]        sum_add;

  assign skip_k   = (i == j) || (k == i) || (k == j);
  assign k_last   = (k == nm1);
  assign j_last   = (j == nm1);
  assign i_last   = (i == nm1);
  assign end_pair = ((gstate == G_K0) && skip_k && k_last) || ((gstate == G_K1) && k_last);

  always_comb begin
    raddr_a = {i, j};
    raddr_b = {k, i};
    case (gstate)
      G_K0: begin
        raddr_a = {j, k};
        raddr_b = {k, i};
      end
      G_K1: begin
        raddr_a = {i, k};
        raddr_b = {k, j};
      end
      default: begin
        raddr_a = {i, j};
        raddr_b = {k, i};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gstate <= G_IDLE;
      op     <= OP_NONE;
    end else begin
      op <= OP_NONE;
      case (gstate)
        G_IDLE: begin
          if (start) begin
            gstate <= G_PAIR;
          end
        end
        G_PAIR: begin
          op     <= OP_PAIR;
          gstate <= G_K0;
        end
        G_K0: begin
          if (!skip_k) begin
            op     <= OP_K0;
            gstate <= G_K1;
          end else if (k_last) begin
            gstate <= (i_last && j_last) ? G_FLUSH : G_PAIR;
          end
        end
        G_K1: begin
          op <= OP_K1;
          if (k_last) begin
            gstate <= (i_last && j_last) ? G_FLUSH : G_PAIR;
          end else begin
            gstate <= G_K0;
          end
        end
        G_FLUSH: begin
          op     <= OP_FLUSH;
          gstate <= G_IDLE;
        end
        default: begin
          gstate <= G_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (gstate == G_IDLE && start) begin
      i <= '0;
      j <= '0;
      k <= '0;
    end else if (gstate == G_PAIR) begin
      k         <= '0;
      pair_init <= (nm1 != '0) && ((i != j) || (nm1 == IW'(1)));
    end else if (end_pair) begin
      if (j_last) begin
        j <= '0;
        if (!i_last) begin
          i <= i + IW'(1);
        end
      end else begin
        j <= j + IW'(1);
      end
    end else if ((gstate == G_K0 && skip_k) || gstate == G_K1) begin
      k <= k + IW'(1);
    end
  end

  // detour checks: d(i,j)+d(j,k) vs d(k,i), and d(i,k)+d(k,j) vs d(i,j)
  assign k0_lhs  = DW1'(dij) + DW1'(rdata_a);
  assign k1_rhs  = DW1'(rdata_a) + DW1'(rdata_b);
  assign sum_add = sum + (needed ? SW'(dij) : SW'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (op == OP_FLUSH);
    end
  end

  always_ff @(posedge clk) begin
    if (gstate == G_IDLE && start) begin
      viol   <= 1'b0;
      sum    <= '0;
      needed <= 1'b0;
    end else begin
      case (op)
        OP_PAIR: begin
          sum    <= sum_add;
          dij    <= rdata_a;
          needed <= pair_init;
        end
        OP_K0: begin
          if (k0_lhs < DW1'(rdata_b)) begin
            viol <= 1'b1;
          end
        end
        OP_K1: begin
          if (!(DW1'(dij) < k1_rhs)) begin
            needed <= 1'b0;
          end
        end
        OP_FLUSH: begin
          result.status       <= viol;
          result.total_length <= viol ? '0 : dmrr_pkg::TOTAL_W'(sum_add >> 1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: sv/distance_matrix_road_restore.sv
// Top level of the distance matrix road restoration block.
// Loads an n-by-n distance matrix (n from matrix_size, 0 taken as 1, capped at
// MAX_NODES) one entry per cycle in row-major order while not evaluating, then
// checks the triangle inequality over all distinct triples and sums the
// entries that no detour matches, emitting one result per matrix. The
// evaluation is paced by the two-read-port distance store, which serves one
// pair of reads per cycle. The next matrix may load while a result waits on
// the output; its last entry is held until that result is taken. Writing
// matrix_size restarts loading at (0,0).
module distance_matrix_road_restore #(
  parameter int MAX_NODES = dmrr_pkg::MAX_NODES_DEF,
  parameter int DIST_BITS = dmrr_pkg::DIST_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  dmrr_in_if.sink    din,
  dmrr_out_if.source dout,
  dmrr_cfg_if.sink   cfg
);

  localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int AW = 2 * IW;
  localparam logic [dmrr_pkg::SIZE_EXT_W-1:0] MaxN = dmrr_pkg::SIZE_EXT_W'(MAX_NODES);

  typedef enum logic [1:0] {
    S_LOAD = 2'b01,
    S_EVAL = 2'b10
  } state_t;

  state_t                          state;
  logic [dmrr_pkg::SIZE_W-1:0]     matrix_size;
  logic [IW-1:0]                   row;
  logic [IW-1:0]                   col;
  logic                            out_valid;

  logic [dmrr_pkg::SIZE_EXT_W-1:0] size_ext;
  logic [dmrr_pkg::SIZE_EXT_W-1:0] eff;
  logic [IW-1:0]                   nm1;
  logic                            last;
  logic                            accept;
  logic                            done;
  logic [AW-1:0]                   raddr_a;
  logic [AW-1:0]                   raddr_b;
  logic [DIST_BITS-1:0]            rdata_a;
  logic [DIST_BITS-1:0]            rdata_b;
  dmrr_pkg::result_t               result;

  assign size_ext = dmrr_pkg::SIZE_EXT_W'(matrix_size);

  always_comb begin
    eff = size_ext;
    if (size_ext == '0) begin
      eff = dmrr_pkg::SIZE_EXT_W'(1);
    end else if (size_ext > MaxN) begin
      eff = MaxN;
    end
  end

  assign nm1       = IW'(eff - dmrr_pkg::SIZE_EXT_W'(1));
  assign last      = (row == nm1) && (col == nm1);
  assign din.ready = (state == S_LOAD) && !(last && out_valid);
  assign accept    = din.valid && din.ready;
  assign cfg.ready = 1'b1;

  assign dout.valid        = out_valid;
  assign dout.status       = result.status;
  assign dout.total_length = result.total_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      matrix_size <= dmrr_pkg::SIZE_RESET;
      row         <= '0;
      col         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        matrix_size <= cfg.matrix_size;
        row         <= '0;
        col         <= '0;
      end else if (accept) begin
        if (last) begin
          row   <= '0;
          col   <= '0;
          state <= S_EVAL;
        end else if (col == nm1) begin
          col <= '0;
          row <= row + IW'(1);
        end else begin
          col <= col + IW'(1);
        end
      end
      if (done) begin
        state     <= S_LOAD;
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  dmrr_store #(
    .AW(AW),
    .DW(DIST_BITS)
  ) u_store (
    .clk    (clk),
    .we     (accept),
    .waddr  ({row, col}),
    .wdata  (DIST_BITS'(din.distance)),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  dmrr_eval #(
    .MAX_NODES(MAX_NODES),
    .DIST_BITS(DIST_BITS)
  ) u_eval (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && last),
    .nm1    (nm1),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b),
    .done   (done),
    .result (result)
  );

endmodule

// File: verif/testbench.sv
// Self-checking testbench for distance_matrix_road_restore: streamed matrices, scoreboard check.
module testbench;

  localparam int DIST_W = dmrr_pkg::DIST_W;
  localparam int SIZE_W = dmrr_pkg::SIZE_W;
  localparam int TOTAL_W = dmrr_pkg::TOTAL_W;
  localparam int MAX_NODES_DEF = dmrr_pkg::MAX_NODES_DEF;
  localparam logic [SIZE_W-1:0] SIZE_RESET = dmrr_pkg::SIZE_RESET;
  localparam int STORE_DEPTH = MAX_NODES_DEF * MAX_NODES_DEF;
  localparam int unsigned DIST_MAX = (1 << DIST_W) - 1;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2_000_000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int QUIET_TAIL = 300;

  typedef dmrr_pkg::result_t result_t;
  typedef enum int {SHAPE_METRIC, SHAPE_BAND, SHAPE_NOISE, SHAPE_BROKEN} shape_t;

  logic clk = 1'b0;
  logic rst;

  dmrr_in_if  din ();
  dmrr_out_if dout ();
  dmrr_cfg_if cfg ();

  distance_matrix_road_restore DUT (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout),
    .cfg  (cfg)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state
  logic [DIST_W-1:0] road_len [0:STORE_DEPTH-1];
  logic [SIZE_W-1:0] size_reg = SIZE_RESET;
  int                loaded = 0;
  result_t           awaited [$];
  int                errors = 0;

  // stimulus state
  logic [DIST_W-1:0] grid [0:STORE_DEPTH-1];
  logic [SIZE_W-1:0] size_set = SIZE_RESET;
  bit                calm = 1'b0;
  bit                hold_off = 1'b0;

  function automatic int nodes_of(input logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_NODES_DEF) return MAX_NODES_DEF;
    return int'(s);
  endfunction

  function automatic longint unsigned len_at(input int n, input int r, input int c);
    return longint'(road_len[r * n + c]);
  endfunction

  function automatic result_t judge_matrix(input int n);
    result_t r;
    bit broken;
    bit needed;
    longint unsigned sum;
    broken = 1'b0;
    sum = 0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        for (int k = 0; k < n; k++)
          if (i != j && i != k && j != k &&
              len_at(n, i, j) + len_at(n, j, k) < len_at(n, k, i))
            broken = 1'b1;
    if (broken) begin
      r.status = 1'b1;
      r.total_length = '0;
      return r;
    end
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++) begin
        needed = (n >= 2) && (i != j || n == 2);
        for (int k = 0; k < n; k++)
          if (needed && i != j && i != k && j != k &&
              !(len_at(n, i, j) < len_at(n, i, k) + len_at(n, k, j)))
            needed = 1'b0;
        if (needed) sum += len_at(n, i, j);
      end
    r.status = 1'b0;
    r.total_length = TOTAL_W'(sum >> 1);
    return r;
  endfunction

  always @(posedge clk) begin : predictor
    int n;
    if (rst) begin
      size_reg = SIZE_RESET;
      loaded = 0;
    end else begin
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        size_reg = cfg.matrix_size;
        loaded = 0;
      end
      if (din.valid === 1'b1 && din.ready === 1'b1) begin
        n = nodes_of(size_reg);
        road_len[loaded] = din.distance;
        loaded++;
        if (loaded == n * n) begin
          loaded = 0;
          awaited.push_back(judge_matrix(n));
        end
      end
    end
  end

  always @(posedge clk) begin : result_checker
    result_t want;
    if (!rst && dout.valid === 1'b1 && dout.ready === 1'b1) begin
      if (awaited.size() == 0) begin
        $error("unexpected result: status %0d total_length %0d",
               dout.status, dout.total_length);
        errors++;
      end else begin
        want = awaited.pop_front();
        if (dout.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, dout.status);
          errors++;
        end
        if (dout.total_length !== want.total_length) begin
          $error("total_length: expected %0d, actual %0d",
                 want.total_length, dout.total_length);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int stall_cycles;
    if (rst || (din.valid === 1'b1 && din.ready === 1'b1) ||
        (dout.valid === 1'b1 && dout.ready === 1'b1) ||
        (cfg.valid === 1'b1 && cfg.ready === 1'b1))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : result_receiver
    int gap;
    dout.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        dout.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 10);
        dout.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        dout.ready <= 1'b1;
      end
    end
  end

  task automatic send_entry(input logic [DIST_W-1:0] d);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      @(negedge clk);
      din.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    din.valid <= 1'b1;
    din.distance <= d;
    do @(posedge clk); while (din.ready !== 1'b1);
  endtask

  task automatic send_grid(input int count);
    for (int i = 0; i < count; i++) send_entry(grid[i]);
  endtask

  // register writes only with the block idle and nothing outstanding
  task automatic write_size(input logic [SIZE_W-1:0] sz);
    @(negedge clk);
    din.valid <= 1'b0;
    do @(posedge clk); while (awaited.size() != 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.matrix_size <= sz;
    do @(posedge clk); while (cfg.ready !== 1'b1);
    @(negedge clk);
    cfg.valid <= 1'b0;
    size_set = sz;
  endtask

  task automatic build_matrix(input int n, input shape_t shape);
    longint unsigned w [0:STORE_DEPTH-1];
    longint unsigned via;
    int unsigned cap;
    int i;
    int j;
    case ($urandom_range(0, 2))
      0: cap = 3;
      1: cap = 1000;
      default: cap = DIST_MAX;
    endcase
    for (int r = 0; r < n; r++) begin
      w[r * n + r] = 0;
      for (int c = r + 1; c < n; c++) begin
        w[r * n + c] = $urandom_range(0, cap);
        w[c * n + r] = w[r * n + c];
      end
    end
    for (int k = 0; k < n; k++)
      for (int r = 0; r < n; r++)
        for (int c = 0; c < n; c++) begin
          via = w[r * n + k] + w[k * n + c];
          if (via < w[r * n + c]) w[r * n + c] = via;
        end
    for (int e = 0; e < n * n; e++) begin
      case (shape)
        SHAPE_BAND:
          grid[e] = DIST_W'(($urandom_range(0, 7) == 0) ? DIST_MAX :
                            $urandom_range(1 << 29, DIST_MAX));
        SHAPE_NOISE:
          grid[e] = DIST_W'($urandom_range(0, cap));
        default:
          grid[e] = DIST_W'(w[e]);
      endcase
      if (e % (n + 1) == 0) grid[e] = DIST_W'($urandom_range(0, DIST_MAX));
    end
    if (shape == SHAPE_BROKEN && n >= 3) begin
      i = $urandom_range(0, n - 1);
      j = (i + 1 + $urandom_range(0, n - 2)) % n;
      grid[i * n + j] = DIST_W'($urandom_range(grid[i * n + j], DIST_MAX));
    end
  endtask

  task automatic test_corner_matrices();
    logic [DIST_W-1:0] detour_tie [0:8] = '{0, 1, 2, 1, 0, 1, 2, 1, 0};
    logic [DIST_W-1:0] bad_triangle [0:8] = '{0, 1, 5, 1, 0, 1, 5, 1, 0};
    // size 3 from reset: equal detour, then a violated triangle
    foreach (detour_tie[i]) send_entry(detour_tie[i]);
    foreach (bad_triangle[i]) send_entry(bad_triangle[i]);
    write_size(SIZE_W'(1));
    send_entry('0);
    send_entry(DIST_W'(DIST_MAX));
    // size 2: diagonal counts
    write_size(SIZE_W'(2));
    repeat (4) send_entry(DIST_W'(DIST_MAX));
    // size 0 acts as 1
    write_size(SIZE_W'(0));
    send_entry(DIST_W'(32'h2AAA_AAAA));
  endtask

  task automatic test_output_backpressure();
    write_size(SIZE_W'(2));
    calm = 1'b1;
    hold_off = 1'b1;
    repeat (6) begin
      build_matrix(2, SHAPE_METRIC);
      send_grid(4);
    end
    wait (!hold_off);
    calm = 1'b0;
  endtask

  task automatic test_restart_mid_load();
    write_size(SIZE_W'(MAX_NODES_DEF));
    build_matrix(MAX_NODES_DEF, SHAPE_BAND);
    send_grid(10);
    // oversize saturates to the largest matrix, also dropped mid-load
    write_size(7'd127);
    send_grid(10);
    write_size(SIZE_W'(5));
    build_matrix(5, SHAPE_METRIC);
    send_grid(25);
  endtask

  task automatic test_random_matrices();
    int sent;
    int n;
    int pick;
    shape_t shape;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent >= RANDOM_ITEMS - QUIET_TAIL) || ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) write_size(SIZE_W'(0));
        else if (pick == 1) write_size(SIZE_W'($urandom_range(9, 16)));
        else write_size(SIZE_W'($urandom_range(1, 8)));
      end
      n = nodes_of(size_set);
      pick = $urandom_range(0, 9);
      if (pick < 5) shape = SHAPE_METRIC;
      else if (pick < 7) shape = SHAPE_BAND;
      else if (pick < 8) shape = SHAPE_NOISE;
      else shape = SHAPE_BROKEN;
      build_matrix(n, shape);
      send_grid(n * n);
      sent += n * n;
    end
  endtask

  initial begin
    rst = 1'b1;
    din.valid = 1'b0;
    din.distance = '0;
    cfg.valid = 1'b0;
    cfg.matrix_size = SIZE_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_corner_matrices();
    test_output_backpressure();
    test_restart_mid_load();
    test_random_matrices();

    calm = 1'b1;
    @(negedge clk);
    din.valid <= 1'b0;
    do @(posedge clk); while (awaited.size() != 0);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
